>>> hw/rtl/kmlr_pkg.sv
// ----------------------------------------------------------------------------
// kmlr_pkg
// Shared types and constants for the keymap layer resolver.
// ----------------------------------------------------------------------------
package kmlr_pkg;

    localparam int KEY_W   = 16;
    localparam int LIDX_W  = 3;
    localparam int MASK_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_A_W = 1;

    typedef enum logic [KIND_W-1:0] {
        K_LAYER_ON  = 2'd0,
        K_LAYER_OFF = 2'd1,
        K_RESOLVE   = 2'd2,
        K_WRITE     = 2'd3
    } t_kind;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_DEFAULT_LAYER = 1'd0,
        CFG_TRANSPARENT   = 1'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        WK_IDLE,
        WK_SCAN,
        WK_CHECK,
        WK_FALL,
        WK_FALLCHK
    } t_walk_state;

    // walker result toward the output register
    typedef struct packed {
        logic              done;
        logic [KEY_W-1:0]  keycode;
        logic [LIDX_W-1:0] source;
    } t_walk_res;

endpackage

>>> hw/rtl/kmlr_store.sv
// ----------------------------------------------------------------------------
// kmlr_store
// Keymap memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kmlr_store
    import kmlr_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [KEY_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [KEY_W-1:0] o_rdata
);

    localparam int DEPTH = 2 ** AW;

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/kmlr_walk.sv
// ----------------------------------------------------------------------------
// kmlr_walk
// Layer walk sequencer: steps from the top layer down, one keymap read and
// one transparent-code compare per active layer, then the fallback read.
// ----------------------------------------------------------------------------
module kmlr_walk
    import kmlr_pkg::*;
#(
    parameter int LAYERS = 8,
    parameter int LW     = 3,
    parameter int RW     = 3,
    parameter int CW     = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RW-1:0]     i_row,
    input  logic [CW-1:0]     i_col,
    input  logic [MASK_W-1:0] i_mask,
    input  logic [LIDX_W-1:0] i_dflt,
    input  logic [KEY_W-1:0]  i_tc,
    output logic              o_busy,
    output logic              o_rd_en,
    output logic [LW+RW+CW-1:0] o_rd_addr,
    input  logic [KEY_W-1:0]  i_rd_data,
    output t_walk_res         o_res
);

    t_walk_state r_state, n_state;
    logic [LW-1:0]     r_idx, n_idx;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [MASK_W-1:0] r_mask;
    logic [LIDX_W-1:0] r_dflt;
    logic [KEY_W-1:0]  r_tc;
    logic              w_active;
    logic              w_dflt_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_start) begin
            r_row  <= i_row;
            r_col  <= i_col;
            r_mask <= i_mask;
            r_dflt <= i_dflt;
            r_tc   <= i_tc;
        end
    end

    // default layer counts as active even with its mask bit clear
    assign w_active  = r_mask[LIDX_W'(r_idx)] || (LIDX_W'(r_idx) == r_dflt);
    assign w_dflt_ok = ({1'b0, r_dflt} < (LIDX_W+1)'(LAYERS));
    assign o_busy    = (r_state != WK_IDLE);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        o_rd_en   = 1'b0;
        o_rd_addr = {r_idx, r_row, r_col};
        o_res     = '0;
        unique case (r_state)
            WK_IDLE: begin
                if (i_start) begin
                    n_state = WK_SCAN;
                    n_idx   = LW'(LAYERS - 1);
                end
            end
            WK_SCAN: begin
                if (w_active) begin
                    o_rd_en = 1'b1;
                    n_state = WK_CHECK;
                end else if (r_idx == '0) begin
                    n_state = WK_FALL;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            WK_CHECK: begin
                if (i_rd_data != r_tc) begin
                    o_res.done    = 1'b1;
                    o_res.keycode = i_rd_data;
                    o_res.source  = LIDX_W'(r_idx);
                    n_state       = WK_IDLE;
                end else if (r_idx == '0) begin
                    n_state = WK_FALL;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = WK_SCAN;
                end
            end
            WK_FALL: begin
                if (w_dflt_ok) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = {LW'(r_dflt), r_row, r_col};
                    n_state   = WK_FALLCHK;
                end else begin
                    // default layer beyond the store: keycode zero
                    o_res.done   = 1'b1;
                    o_res.source = r_dflt;
                    n_state      = WK_IDLE;
                end
            end
            WK_FALLCHK: begin
                o_res.done    = 1'b1;
                o_res.keycode = i_rd_data;
                o_res.source  = r_dflt;
                n_state       = WK_IDLE;
            end
            default: begin
                n_state = WK_IDLE;
            end
        endcase
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == WK_IDLE))
        else $error("walk started while busy");

    a_check_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == WK_CHECK) |-> ($past(r_state) == WK_SCAN))
        else $error("compare without a preceding keymap read");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done |=> (r_state == WK_IDLE))
        else $error("walk did not return to idle after result");

endmodule

>>> hw/rtl/keymap_layer_resolver_unit.sv
// ----------------------------------------------------------------------------
// keymap_layer_resolver_unit
// Active layer mask plus keymap store; resolves a key to the keycode of the
// highest active non-transparent layer, falling back to the default layer.
// ----------------------------------------------------------------------------
// Direct requests: layer on/off, keymap write and off-matrix resolve load the
//   result register on acceptance. Resolve: skips inactive layers, reads and
//   compares each active layer visited, then the fallback if all transparent.
// Throughput: one request at a time; the single keymap read port in the walk loop
//   sets the resolve time. Accepts when the walk is idle and the result slot frees.
// Reset: clears layer mask and output valid; default layer 0, transparent 1.
//   Keymap contents are undefined until written; no clearing pass.
module keymap_layer_resolver_unit
    import kmlr_pkg::*;
#(
    parameter int LAYERS  = 8,
    parameter int ROWS    = 8,
    parameter int COLUMNS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_idx,
    input  logic [KEY_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [3:0]         i_layer,
    input  logic [2:0]         i_row,
    input  logic [3:0]         i_column,
    input  logic [KEY_W-1:0]   i_entry_code,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [KEY_W-1:0]   o_keycode,
    output logic [LIDX_W-1:0]  o_source_layer,
    output logic [MASK_W-1:0]  o_layer_mask
);

    localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int AW = LW + RW + CW;

    logic [LIDX_W-1:0] r_dflt;
    logic [KEY_W-1:0]  r_tc;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic              r_out_valid;
    logic [KEY_W-1:0]  r_keycode;
    logic [LIDX_W-1:0] r_source;
    logic [MASK_W-1:0] r_out_mask;

    t_kind             w_kind;
    logic              w_accept;
    logic              w_layer_ok;
    logic              w_pos_ok;
    logic              w_start;
    logic              w_direct;
    logic              w_we;
    logic              w_busy;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [KEY_W-1:0]  w_rd_data;
    logic [LW-1:0]     w_lay;
    logic [RW-1:0]     w_row;
    logic [CW-1:0]     w_col;
    t_walk_res         w_res;

    assign w_kind     = t_kind'(i_kind);
    assign o_in_ready = !w_busy && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_layer_ok = (i_layer < 4'(LAYERS));
    assign w_pos_ok   = ({3'b000, i_row} < 6'(ROWS)) && ({2'b00, i_column} < 6'(COLUMNS));
    assign w_lay      = LW'(i_layer);
    assign w_row      = RW'(i_row);
    assign w_col      = CW'(i_column);
    assign w_start    = w_accept && (w_kind == K_RESOLVE) && w_pos_ok;
    assign w_direct   = w_accept && !w_start;
    assign w_we       = w_accept && (w_kind == K_WRITE) && w_layer_ok && w_pos_ok;

    always_comb begin
        n_mask = r_mask;
        if (w_accept && w_layer_ok) begin
            case (w_kind)
                K_LAYER_ON:  n_mask[i_layer[LIDX_W-1:0]] = 1'b1;
                K_LAYER_OFF: n_mask[i_layer[LIDX_W-1:0]] = 1'b0;
                default:     n_mask = r_mask;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt      <= '0;
            r_tc        <= KEY_W'(1);
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_DEFAULT_LAYER: r_dflt <= i_cfg_data[LIDX_W-1:0];
                    CFG_TRANSPARENT:   r_tc   <= i_cfg_data;
                    default:           r_tc   <= r_tc;
                endcase
            end
            r_mask <= n_mask;
            if (w_direct || w_res.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_direct) begin
            r_keycode  <= '0;
            r_source   <= '0;
            r_out_mask <= n_mask;
        end else if (w_res.done) begin
            r_keycode  <= w_res.keycode;
            r_source   <= w_res.source;
            r_out_mask <= r_mask;
        end
    end

    kmlr_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({w_lay, w_row, w_col}),
        .i_wdata (i_entry_code),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    kmlr_walk #(
        .LAYERS (LAYERS),
        .LW     (LW),
        .RW     (RW),
        .CW     (CW)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_row     (w_row),
        .i_col     (w_col),
        .i_mask    (r_mask),
        .i_dflt    (r_dflt),
        .i_tc      (r_tc),
        .o_busy    (w_busy),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_res     (w_res)
    );

    assign o_out_valid    = r_out_valid;
    assign o_keycode      = r_keycode;
    assign o_source_layer = r_source;
    assign o_layer_mask   = r_out_mask;

    a_slot_free_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> !r_out_valid)
        else $error("walk result with output slot occupied");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !r_out_valid)
        else $error("resolve result appeared before the walk");

    a_mask_stable_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |=> $stable(r_mask))
        else $error("layer mask changed during a walk");

endmodule
